// ----- rtl/core/bezier_patch_tessellator_assert.svh -----
// Assertion macros used by the tessellator controller.
`ifndef BEZIER_PATCH_TESSELLATOR_ASSERT_SVH
`define BEZIER_PATCH_TESSELLATOR_ASSERT_SVH

// Checked property, masked while rst is high
`define BPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also during reset
`define BPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bpt_pkg.sv -----
`default_nettype none

package bpt_pkg;

  localparam int COMP_N   = 10;
  localparam int COMP_W   = 32;
  localparam int CTL_W    = COMP_N * COMP_W;
  localparam int IDX_W    = 24;
  localparam int DATA_W   = CTL_W + IDX_W;
  localparam int LVL_W    = 3;
  localparam int W_W      = 17;
  localparam int PROD_W   = COMP_W + W_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int SLOT_W   = 4;
  localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd8;
  localparam logic [W_W-1:0] WONE = 17'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic              ld_en;
    logic [SLOT_W-1:0] ld_slot;
    logic              ld_base;
    logic              rd_en;
    logic              rd_row;
    logic [SLOT_W-1:0] rd_addr;
    logic [LVL_W-1:0]  lvl;
    logic [LVL_W-1:0]  t;
    logic [1:0]        k;
    logic              wr_row;
    logic [1:0]        wr_row_addr;
    logic              wr_out;
    logic              last;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_free;
  } sts_t;

  // Outer Bernstein weight round(W*(l-t)^2/l^2), t in 0..l
  function automatic logic [W_W-1:0] w_edge(logic [LVL_W-1:0] l, logic [LVL_W-1:0] t);
    logic [W_W-1:0] w;
    w = '0;
    if (t == '0) begin
      w = WONE;
    end else begin
      case ({l, t})
        {3'd2, 3'd1}: w = 17'd16384;
        {3'd3, 3'd1}: w = 17'd29127;
        {3'd3, 3'd2}: w = 17'd7282;
        {3'd4, 3'd1}: w = 17'd36864;
        {3'd4, 3'd2}: w = 17'd16384;
        {3'd4, 3'd3}: w = 17'd4096;
        {3'd5, 3'd1}: w = 17'd41943;
        {3'd5, 3'd2}: w = 17'd23593;
        {3'd5, 3'd3}: w = 17'd10486;
        {3'd5, 3'd4}: w = 17'd2621;
        {3'd6, 3'd1}: w = 17'd45511;
        {3'd6, 3'd2}: w = 17'd29127;
        {3'd6, 3'd3}: w = 17'd16384;
        {3'd6, 3'd4}: w = 17'd7282;
        {3'd6, 3'd5}: w = 17'd1820;
        {3'd7, 3'd1}: w = 17'd48149;
        {3'd7, 3'd2}: w = 17'd33437;
        {3'd7, 3'd3}: w = 17'd21400;
        {3'd7, 3'd4}: w = 17'd12037;
        {3'd7, 3'd5}: w = 17'd5350;
        {3'd7, 3'd6}: w = 17'd1337;
        default:      w = '0;
      endcase
    end
    return w;
  endfunction

  // Weight k of three at parameter t/l; the three always sum to one
  function automatic logic [W_W-1:0] bez_weight(logic [LVL_W-1:0] l, logic [LVL_W-1:0] t,
                                                logic [1:0] k);
    logic [W_W-1:0] w0;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w;
    w0 = w_edge(l, t);
    w2 = w_edge(l, l - t);
    case (k)
      2'd0:    w = w0;
      2'd2:    w = w2;
      default: w = WONE - w0 - w2;
    endcase
    return w;
  endfunction

  // floor(s / 65536 + 0.5), saturated to signed 32 bits
  function automatic logic [COMP_W-1:0] round_sat(logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-17:0] q;
    logic [COMP_W-1:0] y;
    r = s + ACC_W'(32768);
    q = r[ACC_W-1:16];
    if (q > (ACC_W-16)'(64'sh7FFFFFFF)) begin
      y = 32'h7FFF_FFFF;
    end else if (q < -(ACC_W-16)'(64'sh80000000)) begin
      y = 32'h8000_0000;
    end else begin
      y = q[COMP_W-1:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bezier_patch_tessellator.sv -----
// Biquadratic Bezier patch tessellator.
// Input stream s_axis: one control vertex per transaction, nine per patch in
// row-major order; tlast marks the ninth, whose tdata also carries the base
// vertex number. Output stream m_axis: (L+1)^2 grid vertices, i outer, j inner,
// tlast on the final one. Level L (1..7, 0 acts as 1) is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, as the
// block itself does not enforce it; reset value 5. Control vertices are
// accepted while idle. The final one starts the grid: each blend uses ten
// parallel multiply-accumulate lanes over three weighted terms plus a
// two-stage drain. Each grid row costs three row blends then L+1 vertex
// blends; s_axis_tready stays low until the last grid vertex is written.
// The result sits in an output register; a stalled receiver holds it, and
// the next vertex blend waits before its write until it is taken.
// Reset clears the load count and control and sets the level to 5; stored
// points are kept undefined until written.
`default_nettype none

module bezier_patch_tessellator (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [bpt_pkg::LVL_W-1:0]  cfg_wdata,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, lm_u, lm_v, norm_x, norm_y, norm_z, first_vertex
  input  wire  [bpt_pkg::DATA_W-1:0] s_axis_tdata,
  input  wire                        s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, out_lm_u, out_lm_v,
  // out_norm_x, out_norm_y, out_norm_z, vertex_index
  output logic [bpt_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);

  bpt_pkg::cmd_t cmd;
  bpt_pkg::sts_t sts;

  bpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (s_axis_tdata),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bpt_datapath.sv -----
`default_nettype none

module bpt_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  bpt_pkg::cmd_t               cmd,
  input  wire  [bpt_pkg::DATA_W-1:0]  in_data,
  input  wire                         out_ready,
  output logic                        out_valid,
  output logic [bpt_pkg::DATA_W-1:0]  out_data,
  output logic                        out_last,
  output bpt_pkg::sts_t               sts
);

  logic [bpt_pkg::CTL_W-1:0] ctl_mem [9];
  logic [bpt_pkg::CTL_W-1:0] row_mem [3];
  logic [bpt_pkg::CTL_W-1:0] ctl_q;
  logic [bpt_pkg::CTL_W-1:0] row_q;
  logic                      src_row;
  logic [bpt_pkg::W_W-1:0]   w_q;
  logic                      v1;
  logic                      first1;
  logic                      v2;
  logic                      first2;
  logic [bpt_pkg::IDX_W-1:0] vidx;
  logic [bpt_pkg::CTL_W-1:0] rnd;

  // control point store and row blend store, registered reads
  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      ctl_mem[cmd.ld_slot] <= in_data[bpt_pkg::CTL_W-1:0];
    end
    if (cmd.wr_row) begin
      row_mem[cmd.wr_row_addr] <= rnd;
    end
    if (cmd.rd_en) begin
      ctl_q   <= ctl_mem[cmd.rd_addr];
      row_q   <= row_mem[cmd.rd_addr[1:0]];
      src_row <= cmd.rd_row;
      w_q     <= bpt_pkg::bez_weight(cmd.lvl, cmd.t, cmd.k);
    end
  end

  // term valids through the multiply and accumulate stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (cmd.k == 2'd0);
    first2 <= first1;
  end

  // one multiply-accumulate lane per component
  for (genvar l = 0; l < bpt_pkg::COMP_N; l++) begin : g_lane
    logic signed [bpt_pkg::COMP_W-1:0] opnd;
    logic signed [bpt_pkg::PROD_W-1:0] prod;
    logic signed [bpt_pkg::ACC_W-1:0]  acc;
    assign opnd = src_row ? row_q[l*bpt_pkg::COMP_W +: bpt_pkg::COMP_W]
                          : ctl_q[l*bpt_pkg::COMP_W +: bpt_pkg::COMP_W];

    always_ff @(posedge clk) begin
      if (v1) begin
        prod <= opnd * $signed({1'b0, w_q});
      end
      if (v2) begin
        acc <= first2 ? bpt_pkg::ACC_W'(prod) : acc + bpt_pkg::ACC_W'(prod);
      end
    end

    assign rnd[l*bpt_pkg::COMP_W +: bpt_pkg::COMP_W] = bpt_pkg::round_sat(acc);
  end

  // output register, free when empty or being taken
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // vertex numbering runs from the base in emission order
  always_ff @(posedge clk) begin
    if (cmd.ld_base) begin
      vidx <= in_data[bpt_pkg::DATA_W-1:bpt_pkg::CTL_W];
    end else if (cmd.wr_out) begin
      vidx <= vidx + 1'b1;
    end
    if (cmd.wr_out) begin
      out_data <= {vidx, rnd};
      out_last <= cmd.last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bpt_ctrl.sv -----
`default_nettype none
`include "bezier_patch_tessellator_assert.svh"

module bpt_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire  [bpt_pkg::LVL_W-1:0]  cfg_wdata,
  input  wire                        in_valid,
  input  wire                        in_last,
  output logic                       in_ready,
  input  bpt_pkg::sts_t              sts,
  output bpt_pkg::cmd_t              cmd
);

  bpt_pkg::state_t state;
  bpt_pkg::state_t state_next;
  logic [bpt_pkg::LVL_W-1:0] level;
  logic [bpt_pkg::LVL_W-1:0] lvl;
  logic [3:0]                loaded;
  logic [bpt_pkg::LVL_W-1:0] grid_row;
  logic [bpt_pkg::LVL_W-1:0] grid_col;
  logic [1:0]                rsel;
  logic [1:0]                k;
  logic                      drain;
  logic                      col_phase;
  logic                      accept;
  logic                      grid_end;
  logic                      wr_fire;

  assign lvl      = (level == '0) ? bpt_pkg::LVL_W'(1) : level;
  assign accept   = in_valid && in_ready;
  assign grid_end = (grid_row == lvl) && (grid_col == lvl);
  assign wr_fire  = (state == bpt_pkg::ST_WRITE) && (!col_phase || sts.out_free);

  // tessellation level register
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= bpt_pkg::LVL_W'(5);
    end else if (cfg_we) begin
      level <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpt_pkg::ST_IDLE:  if (accept && in_last) state_next = bpt_pkg::ST_ISSUE;
      bpt_pkg::ST_ISSUE: if (k == 2'd2) state_next = bpt_pkg::ST_DRAIN;
      bpt_pkg::ST_DRAIN: if (drain) state_next = bpt_pkg::ST_WRITE;
      bpt_pkg::ST_WRITE: begin
        if (wr_fire) begin
          state_next = (col_phase && grid_end) ? bpt_pkg::ST_IDLE : bpt_pkg::ST_ISSUE;
        end
      end
      default: state_next = bpt_pkg::ST_IDLE;
    endcase
  end

  // state and grid counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpt_pkg::ST_IDLE;
      loaded    <= '0;
      grid_row  <= '0;
      grid_col  <= '0;
      rsel      <= '0;
      k         <= '0;
      drain     <= 1'b0;
      col_phase <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (in_last) begin
          loaded    <= '0;
          grid_row  <= '0;
          grid_col  <= '0;
          rsel      <= '0;
          k         <= '0;
          drain     <= 1'b0;
          col_phase <= 1'b0;
        end else if (loaded < 4'd8) begin
          loaded <= loaded + 1'b1;
        end
      end
      if (state == bpt_pkg::ST_ISSUE) begin
        k <= (k == 2'd2) ? 2'd0 : k + 1'b1;
      end
      if (state == bpt_pkg::ST_DRAIN) begin
        drain <= ~drain;
      end
      if (wr_fire) begin
        if (!col_phase) begin
          if (rsel == 2'd2) begin
            rsel      <= '0;
            col_phase <= 1'b1;
            grid_col  <= '0;
          end else begin
            rsel <= rsel + 1'b1;
          end
        end else if (grid_col == lvl) begin
          if (grid_row != lvl) begin
            grid_row  <= grid_row + 1'b1;
            col_phase <= 1'b0;
          end
        end else begin
          grid_col <= grid_col + 1'b1;
        end
      end
    end
  end

  // command outputs
  always_comb begin
    in_ready        = (state == bpt_pkg::ST_IDLE);
    cmd             = '0;
    cmd.ld_en       = accept && (in_last || loaded < 4'd8);
    cmd.ld_slot     = in_last ? bpt_pkg::LAST_SLOT : loaded;
    cmd.ld_base     = accept && in_last;
    cmd.rd_en       = (state == bpt_pkg::ST_ISSUE);
    cmd.rd_row      = col_phase;
    cmd.rd_addr     = col_phase ? {2'b00, k}
                                : ({2'b00, rsel} + {1'b0, rsel, 1'b0} + {2'b00, k});
    cmd.lvl         = lvl;
    cmd.t           = col_phase ? grid_col : grid_row;
    cmd.k           = k;
    cmd.wr_row      = wr_fire && !col_phase;
    cmd.wr_row_addr = rsel;
    cmd.wr_out      = wr_fire && col_phase;
    cmd.last        = grid_end;
  end

  `BPT_ASSERT(a_out_free, cmd.wr_out |-> sts.out_free, "output written while occupied")
  `BPT_ASSERT(a_no_read_idle, in_ready |-> !cmd.rd_en, "read issued while taking input")
  `BPT_ASSERT(a_start, (accept && in_last) |=> (state == bpt_pkg::ST_ISSUE), "no start")
  `BPT_ASSERT(a_loaded, loaded <= 4'd8, "load count past eight")
  `BPT_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == bpt_pkg::ST_IDLE && loaded == '0), "reset")

endmodule

`default_nettype wire
